// ===== rtl/cbps_pkg.sv =====
// Shared constants and types for the cubic Bezier point stepper.
package cbps_pkg;

    localparam int COORD_BITS = 16;            // width of a coordinate
    localparam int SEG_BITS   = 10;            // width of the segment count
    localparam int U_BITS     = 17;            // curve parameter, Q0.16 plus the value one
    localparam int DIV_STEPS  = U_BITS;        // one quotient bit per divider cycle
    localparam int CFG_BITS   = 32;            // widest configuration register
    localparam int CNT_BITS   = $clog2(DIV_STEPS);

    typedef enum logic [2:0] {
        CFG_START_X   = 3'd0,
        CFG_START_Y   = 3'd1,
        CFG_START_Z   = 3'd2,
        CFG_END_X     = 3'd3,
        CFG_END_Y     = 3'd4,
        CFG_END_Z     = 3'd5,
        CFG_LIFT_PAIR = 3'd6,
        CFG_SEG_COUNT = 3'd7
    } t_cfg_idx;

    typedef struct packed {
        logic                start;
        logic [SEG_BITS-1:0] num;
        logic [SEG_BITS-1:0] den;
    } t_div_req;

    typedef struct packed {
        logic              done;
        logic [U_BITS-1:0] quo;
    } t_div_rsp;

endpackage

// ===== rtl/cbps_div.sv =====
// Radix-2 restoring divider that forms floor(num * 2^16 / den), one bit a cycle.
module cbps_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  cbps_pkg::t_div_req i_req,
    output cbps_pkg::t_div_rsp o_rsp
);
    import cbps_pkg::*;

    logic                r_busy;
    logic                r_done;
    logic [CNT_BITS-1:0] r_cnt;
    logic [SEG_BITS-1:0] r_rem;
    logic [SEG_BITS-1:0] r_den;
    logic [U_BITS-1:0]   r_quo;

    logic [SEG_BITS:0]   n_trial;
    logic [SEG_BITS:0]   n_diff;
    logic                n_ge;

    // The first step weighs the numerator itself, since it may equal the divisor.
    always_comb begin
        n_trial = (r_cnt == '0) ? {1'b0, r_rem} : {r_rem, 1'b0};
        n_ge    = n_trial >= {1'b0, r_den};
        n_diff  = n_trial - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_BITS'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.num;
            r_den <= i_req.den;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= n_ge ? n_diff[SEG_BITS-1:0] : n_trial[SEG_BITS-1:0];
            r_quo <= {r_quo[U_BITS-2:0], n_ge};
        end
    end

    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

endmodule

// ===== rtl/cubic_bezier_point_stepper_core.sv =====
// Top level of the cubic Bezier point stepper: sequencer, shared multiplier and output register.
//
// Each accepted input word asks for the next point of a cubic Bezier lift curve
// whose control points come from the configuration registers. If restart is set
// the step counter is cleared first. One output word carries x, y, z (signed
// Q5.10, saturated) and at_end, which flags the point at t equal to one.
// The input channel is stalled while a word is being worked on. A word passes
// first through the bit-serial divider that forms t = step / segments, then
// through one 34 x 18 bit multiplier that forms the three products of t, the
// four Bernstein weights and the twelve weighted control point terms, and
// last through a step that rounds and saturates.
// The next word may be accepted in the cycle in which the result appears, so the
// block takes a new word only once it is through with the last one.
// If the receiver stalls, the finished result waits in the output register and
// the block stays busy on a completed word until that register is free.
// Reset is synchronous: it empties the output, clears the step counter and
// restores the configuration to its reset values. The user must write configuration
// only while the block is idle; the block itself does not enforce this.
module cubic_bezier_point_stepper_core (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [2:0]                     i_cfg_index,
    input  logic [cbps_pkg::CFG_BITS-1:0]  i_cfg_data,
    input  logic                           i_in_valid,
    output logic                           o_in_stall,
    input  logic                           i_restart,
    output logic                           o_out_valid,
    input  logic                           i_out_stall,
    output logic signed [cbps_pkg::COORD_BITS-1:0] o_point_x,
    output logic signed [cbps_pkg::COORD_BITS-1:0] o_point_y,
    output logic signed [cbps_pkg::COORD_BITS-1:0] o_point_z,
    output logic                           o_at_end
);
    import cbps_pkg::*;

    localparam int P_BITS    = COORD_BITS + 1;          // control point with lift added
    localparam int W_BITS    = 25;                      // Q0.24 weight up to one
    localparam int SQ_BITS   = 2 * U_BITS - 1;          // u*u, v*v, u*v up to 2^32
    localparam int MA_BITS   = SQ_BITS + 1;             // signed multiplier operand A
    localparam int MB_BITS   = P_BITS + 1;              // signed multiplier operand B
    localparam int PR_BITS   = MA_BITS + MB_BITS;
    localparam int ACC_BITS  = 44;
    localparam int RND_BITS  = ACC_BITS - 24;
    localparam int OP_BITS   = 5;
    localparam int LAST_OP   = 18;                      // seven weight ops, twelve blend ops

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_DIV  = 4'b0010,
        S_MUL  = 4'b0100,
        S_FIN  = 4'b1000
    } t_state;

    typedef enum logic [2:0] {
        K_UU    = 3'd0,
        K_VV    = 3'd1,
        K_UV    = 3'd2,
        K_W0    = 3'd3,
        K_W1    = 3'd4,
        K_W2    = 3'd5,
        K_W3    = 3'd6,
        K_BLEND = 3'd7
    } t_kind;

    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [1:0] axis;
        logic       first;
        logic       last;
    } t_tag;

    // Configuration.
    logic signed [COORD_BITS-1:0] r_start [3];
    logic signed [COORD_BITS-1:0] r_end   [3];
    logic [CFG_BITS-1:0]          r_lift;
    logic [SEG_BITS-1:0]          r_seg_cfg;

    // Control and working state.
    t_state                       r_state, n_state;
    logic [SEG_BITS-1:0]          r_step;
    logic                         r_at_end;
    logic [OP_BITS-1:0]           r_op;
    logic [1:0]                   r_axis;
    logic [1:0]                   r_j;
    logic [U_BITS-1:0]            r_u;
    logic [U_BITS-1:0]            r_v;
    logic [SQ_BITS-1:0]           r_uu, r_vv, r_uv;
    logic [W_BITS-1:0]            r_w [4];
    logic signed [PR_BITS-1:0]    r_prod;
    t_tag                         r_tag;
    logic signed [ACC_BITS-1:0]   r_acc;
    logic signed [ACC_BITS-1:0]   r_res [3];
    logic                         r_out_valid;
    logic signed [COORD_BITS-1:0] r_pt [3];

    logic                         n_accept;
    logic [SEG_BITS-1:0]          n_seg_eff;
    logic [SEG_BITS-1:0]          n_s;
    logic                         n_issue;
    t_tag                         n_tag;
    logic signed [MA_BITS-1:0]    n_ma;
    logic signed [MB_BITS-1:0]    n_mb;
    logic signed [P_BITS-1:0]     n_pa, n_pb, n_p;
    logic [PR_BITS-1:0]           n_prod3;
    logic signed [ACC_BITS-1:0]   n_sum;
    logic                         n_out_free;
    t_div_req                     n_div_req;
    t_div_rsp                     n_div_rsp;

    cbps_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (n_div_req),
        .o_rsp   (n_div_rsp)
    );

    assign n_accept   = i_in_valid && !o_in_stall;
    assign n_out_free = !r_out_valid || !i_out_stall;

    // A zero segment count behaves as one; the counter never runs past the count.
    always_comb begin
        n_seg_eff = (r_seg_cfg == '0) ? SEG_BITS'(1) : r_seg_cfg;
        if (i_restart)
            n_s = '0;
        else
            n_s = (r_step > n_seg_eff) ? n_seg_eff : r_step;
        n_div_req.start = n_accept;
        n_div_req.num   = n_s;
        n_div_req.den   = n_seg_eff;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (n_accept) n_state = S_DIV;
            S_DIV:  if (n_div_rsp.done) n_state = S_MUL;
            S_MUL:  if (r_op == OP_BITS'(LAST_OP + 1)) n_state = S_FIN;
            S_FIN:  if (n_out_free) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control point of the current blend term, with the lifts applied to z only.
    always_comb begin
        n_pa = P_BITS'(r_start[r_axis == 2'd3 ? 2'd0 : r_axis]);
        n_pb = P_BITS'(r_end[r_axis == 2'd3 ? 2'd0 : r_axis]);
        unique case (r_j)
            2'd0: n_p = n_pa;
            2'd1: n_p = (r_axis == 2'd2)
                      ? n_pa + P_BITS'(signed'(r_lift[COORD_BITS-1:0])) : n_pa;
            2'd2: n_p = (r_axis == 2'd2)
                      ? n_pb + P_BITS'(signed'(r_lift[2*COORD_BITS-1:COORD_BITS])) : n_pb;
            default: n_p = n_pb;
        endcase
    end

    // Operand selection for the shared multiplier.
    always_comb begin
        n_issue     = (r_state == S_MUL) && (r_op <= OP_BITS'(LAST_OP));
        n_tag.valid = n_issue;
        n_tag.kind  = K_BLEND;
        n_tag.axis  = r_axis;
        n_tag.first = (r_j == 2'd0);
        n_tag.last  = (r_j == 2'd3);
        n_ma        = signed'({{(MA_BITS-W_BITS){1'b0}}, r_w[r_j]});
        n_mb        = MB_BITS'(n_p);
        unique case (r_op)
            OP_BITS'(0): begin
                n_tag.kind = K_UU;
                n_ma = signed'(MA_BITS'(r_u));
                n_mb = signed'(MB_BITS'(r_u));
            end
            OP_BITS'(1): begin
                n_tag.kind = K_VV;
                n_ma = signed'(MA_BITS'(r_v));
                n_mb = signed'(MB_BITS'(r_v));
            end
            OP_BITS'(2): begin
                n_tag.kind = K_UV;
                n_ma = signed'(MA_BITS'(r_u));
                n_mb = signed'(MB_BITS'(r_v));
            end
            OP_BITS'(3): begin
                n_tag.kind = K_W0;
                n_ma = signed'(MA_BITS'(r_vv));
                n_mb = signed'(MB_BITS'(r_v));
            end
            OP_BITS'(4): begin
                n_tag.kind = K_W1;
                n_ma = signed'(MA_BITS'(r_uv));
                n_mb = signed'(MB_BITS'(r_v));
            end
            OP_BITS'(5): begin
                n_tag.kind = K_W2;
                n_ma = signed'(MA_BITS'(r_uv));
                n_mb = signed'(MB_BITS'(r_u));
            end
            OP_BITS'(6): begin
                n_tag.kind = K_W3;
                n_ma = signed'(MA_BITS'(r_uu));
                n_mb = signed'(MB_BITS'(r_u));
            end
            default: ;
        endcase
    end

    // Three times the product, for the middle weights.
    assign n_prod3 = {3'b0, r_prod[47:0], 1'b0} + {4'b0, r_prod[47:0]};
    assign n_sum   = (r_tag.first ? ACC_BITS'(0) : r_acc) + r_prod[ACC_BITS-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
            r_tag       <= '0;
            r_op        <= '0;
            r_axis      <= '0;
            r_j         <= '0;
            r_start[0]  <= '0;
            r_start[1]  <= '0;
            r_start[2]  <= '0;
            r_end[0]    <= '0;
            r_end[1]    <= '0;
            r_end[2]    <= '0;
            r_lift      <= '0;
            r_seg_cfg   <= SEG_BITS'(1);
        end else begin
            r_state <= n_state;
            r_tag   <= n_tag;

            if (i_cfg_we) begin
                unique case (t_cfg_idx'(i_cfg_index))
                    CFG_START_X:   r_start[0] <= i_cfg_data[COORD_BITS-1:0];
                    CFG_START_Y:   r_start[1] <= i_cfg_data[COORD_BITS-1:0];
                    CFG_START_Z:   r_start[2] <= i_cfg_data[COORD_BITS-1:0];
                    CFG_END_X:     r_end[0]   <= i_cfg_data[COORD_BITS-1:0];
                    CFG_END_Y:     r_end[1]   <= i_cfg_data[COORD_BITS-1:0];
                    CFG_END_Z:     r_end[2]   <= i_cfg_data[COORD_BITS-1:0];
                    CFG_LIFT_PAIR: r_lift     <= i_cfg_data;
                    CFG_SEG_COUNT: r_seg_cfg  <= i_cfg_data[SEG_BITS-1:0];
                    default: ;
                endcase
            end

            if (n_accept)
                r_step <= (n_s == n_seg_eff) ? n_seg_eff : n_s + 1'b1;

            if (r_state == S_DIV) begin
                r_op   <= '0;
                r_axis <= '0;
                r_j    <= '0;
            end else if (r_state == S_MUL) begin
                r_op <= r_op + 1'b1;
                if (r_op >= OP_BITS'(7) && r_op <= OP_BITS'(LAST_OP)) begin
                    r_j <= r_j + 1'b1;
                    if (r_j == 2'd3)
                        r_axis <= r_axis + 1'b1;
                end
            end

            if (r_state == S_FIN && n_out_free)
                r_out_valid <= 1'b1;
            else if (!i_out_stall)
                r_out_valid <= 1'b0;
        end
    end

    // Round half up by the weight scale, then clamp to the coordinate range.
    function automatic logic signed [COORD_BITS-1:0] round_sat(
        input logic signed [ACC_BITS-1:0] acc
    );
        logic signed [ACC_BITS-1:0] biased;
        logic signed [RND_BITS-1:0] q;
        biased = acc + ACC_BITS'(1 << 23);
        q      = biased[ACC_BITS-1:24];
        if (q > RND_BITS'((1 << (COORD_BITS - 1)) - 1))
            round_sat = {1'b0, {(COORD_BITS-1){1'b1}}};
        else if (q < -RND_BITS'(1 << (COORD_BITS - 1)))
            round_sat = {1'b1, {(COORD_BITS-1){1'b0}}};
        else
            round_sat = q[COORD_BITS-1:0];
    endfunction

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        if (n_accept)
            r_at_end <= (n_s == n_seg_eff);
        if (r_state == S_DIV && n_div_rsp.done) begin
            r_u <= n_div_rsp.quo;
            r_v <= U_BITS'(1 << (U_BITS - 1)) - n_div_rsp.quo;
        end
        if (n_issue)
            r_prod <= n_ma * n_mb;
        if (r_tag.valid) begin
            unique case (r_tag.kind)
                K_UU:    r_uu   <= r_prod[SQ_BITS-1:0];
                K_VV:    r_vv   <= r_prod[SQ_BITS-1:0];
                K_UV:    r_uv   <= r_prod[SQ_BITS-1:0];
                K_W0:    r_w[0] <= r_prod[W_BITS+23:24];
                K_W1:    r_w[1] <= n_prod3[W_BITS+23:24];
                K_W2:    r_w[2] <= n_prod3[W_BITS+23:24];
                K_W3:    r_w[3] <= r_prod[W_BITS+23:24];
                K_BLEND: begin
                    if (r_tag.last)
                        r_res[r_tag.axis == 2'd3 ? 2'd0 : r_tag.axis] <= n_sum;
                    else
                        r_acc <= n_sum;
                end
                default: ;
            endcase
        end
        if (r_state == S_FIN && n_out_free) begin
            for (int a = 0; a < 3; a++)
                r_pt[a] <= round_sat(r_res[a]);
            o_at_end <= r_at_end;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_point_x   = r_pt[0];
    assign o_point_y   = r_pt[1];
    assign o_point_z   = r_pt[2];

endmodule

// ===== rtl/cbps_checker.sv =====
// Port-level checks on the cubic Bezier point stepper, bound to its top level.
module cbps_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_valid,
    input logic                                  o_in_stall,
    input logic                                  o_out_valid,
    input logic                                  i_out_stall,
    input logic signed [cbps_pkg::COORD_BITS-1:0] o_point_x,
    input logic signed [cbps_pkg::COORD_BITS-1:0] o_point_y,
    input logic signed [cbps_pkg::COORD_BITS-1:0] o_point_z,
    input logic                                  o_at_end
);
    import cbps_pkg::*;

    // Reset leaves no word in the output register.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // A stalled output word is held unchanged.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_point_x) && $stable(o_point_y)
            && $stable(o_point_z) && $stable(o_at_end))
        else $error("stalled output word changed");

    // An accepted word keeps the block busy in the next cycle.
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input not stalled after acceptance");

    // A new result only appears at the end of a busy period.
    a_result_from_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(o_in_stall))
        else $error("result appeared without work");

endmodule

bind cubic_bezier_point_stepper_core cbps_checker u_cbps_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_point_x   (o_point_x),
    .o_point_y   (o_point_y),
    .o_point_z   (o_point_z),
    .o_at_end    (o_at_end)
);
